/* src/gbf_pkg.sv */
// ----------------------------------------------------------------------------
// gbf_pkg: shared types and constants of the Gaussian broadening FIR
// Register indexes, reset values, request codes, sequencer states and the
// operation codes of the shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
package gbf_pkg;

    // Register and field widths fixed by the programming model
    localparam int HW_W      = 6;
    localparam int SCALE_W   = 20;
    localparam int THR_W     = 15;
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 2;
    localparam int WIDX_W    = 6;
    localparam int WVAL_W    = 16;

    // Scaling works on the accumulator in chunks of this many bits
    localparam int CHUNK_W   = 16;
    // Q1.15 weight times Q4.16 scale leaves this many fraction bits
    localparam int FRAC_BITS = 31;
    // Drain count set on each tap issue and run down before scaling starts
    localparam logic [1:0] TAP_DRAIN = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SCALE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_THRESHOLD = 2'd2;

    // Register reset values
    localparam logic [HW_W-1:0]    HALF_WIDTH_RST   = 6'd4;
    localparam logic [SCALE_W-1:0] OUTPUT_SCALE_RST = 20'd26145;
    localparam logic [THR_W-1:0]   SKIP_THRESH_RST  = 15'd0;

    // Request codes
    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TAP,
        ST_TAP_WAIT,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_ROUND
    } seq_state_t;

    typedef enum logic [1:0] {
        MAC_LOAD,
        MAC_ADD,
        MAC_SHADD
    } mac_op_t;

    typedef struct packed {
        logic    en;
        mac_op_t op;
    } mac_ctl_t;

endpackage

/* src/gbf_store.sv */
// ----------------------------------------------------------------------------
// gbf_store: kernel weight table and circular sample window
// Both memories take one write and one registered read per cycle. The window
// pointer marks the newest sample; older samples sit at decreasing addresses.
// ----------------------------------------------------------------------------
module gbf_store
    import gbf_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 32,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   wt_we,
    input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    wt_waddr,
    input  logic [WVAL_W-1:0]                      wt_wdata,
    input  logic                                   win_we,
    input  logic signed [SAMPLE_BITS-1:0]          win_wdata,
    input  logic [$clog2(2*MAX_HALF_WIDTH)-1:0]    win_raddr,
    input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    wt_raddr,
    output logic signed [SAMPLE_BITS-1:0]          win_rdata,
    output logic [WVAL_W-1:0]                      wt_rdata,
    output logic [$clog2(2*MAX_HALF_WIDTH)-1:0]    head
);

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH;
    localparam int WT_DEPTH  = MAX_HALF_WIDTH + 1;
    localparam int PTR_W     = $clog2(WIN_DEPTH);

    logic signed [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
    logic [WVAL_W-1:0]             wt_mem  [WT_DEPTH];
    logic [PTR_W-1:0]              head_reg;
    logic [PTR_W-1:0]              head_next;
    logic signed [SAMPLE_BITS-1:0] win_rdata_reg;
    logic [WVAL_W-1:0]             wt_rdata_reg;

    // Advance the newest-sample pointer with wrap
    always_comb
    begin
        if (head_reg == PTR_W'(WIN_DEPTH - 1))
        begin
            head_next = '0;
        end
        else
        begin
            head_next = head_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= PTR_W'(WIN_DEPTH - 1);
        end
        else if (win_we)
        begin
            head_reg <= head_next;
        end
    end

    // Window memory: write the new sample, read one tap per cycle
    always_ff @(posedge clk)
    begin
        if (win_we)
        begin
            win_mem[head_next] <= win_wdata;
        end
        win_rdata_reg <= win_mem[win_raddr];
    end

    // Weight memory: load one weight, read one weight per cycle
    always_ff @(posedge clk)
    begin
        if (wt_we)
        begin
            wt_mem[wt_waddr] <= wt_wdata;
        end
        wt_rdata_reg <= wt_mem[wt_raddr];
    end

    assign win_rdata = win_rdata_reg;
    assign wt_rdata  = wt_rdata_reg;
    assign head      = head_reg;

endmodule

/* src/gbf_mac.sv */
// ----------------------------------------------------------------------------
// gbf_mac: shared multiply-accumulate unit
// One registered signed multiplier feeding an accumulator that can load,
// add, or shift by one chunk and add. Taps and output scaling both use it.
// ----------------------------------------------------------------------------
module gbf_mac
    import gbf_pkg::*;
#(
    parameter int A_W = 17,
    parameter int B_W = 21,
    parameter int P_W = 69
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_ctl_t              ctl,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0] acc
);

    logic signed [A_W+B_W-1:0] prod_reg;
    mac_op_t                   op_reg;
    logic                      en_reg;
    logic signed [P_W-1:0]     prod_ext;
    logic signed [P_W-1:0]     acc_reg;
    logic signed [P_W-1:0]     acc_next;

    // Multiply stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
        end
        else
        begin
            en_reg <= ctl.en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        op_reg   <= ctl.op;
    end

    assign prod_ext = P_W'(prod_reg);

    // Accumulate stage
    always_comb
    begin
        acc_next = acc_reg;
        if (en_reg)
        begin
            case (op_reg)
                MAC_LOAD:  acc_next = prod_ext;
                MAC_ADD:   acc_next = acc_reg + prod_ext;
                MAC_SHADD: acc_next = (acc_reg <<< CHUNK_W) + prod_ext;
                default:   acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

/* src/gbf_seq.sv */
// ----------------------------------------------------------------------------
// gbf_seq: output sequencer
// For each pending output walks the taps through the shared unit, then
// scales the sum chunk by chunk, rounds, saturates and hands the result on.
// ----------------------------------------------------------------------------
module gbf_seq
    import gbf_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 32,
    parameter int SAMPLE_BITS    = 16,
    parameter int MUL_A_W        = 17,
    parameter int MUL_B_W        = 21,
    parameter int PROD_W         = 69
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    start_range,
    input  logic [$clog2(2*MAX_HALF_WIDTH+1)-1:0]  start_n,
    input  logic                                   start_end,
    input  logic [SCALE_W-1:0]                     scale,
    input  logic [$clog2(2*MAX_HALF_WIDTH)-1:0]    head,
    output logic [$clog2(2*MAX_HALF_WIDTH)-1:0]    win_raddr,
    output logic [$clog2(MAX_HALF_WIDTH+1)-1:0]    wt_raddr,
    input  logic signed [SAMPLE_BITS-1:0]          win_rdata,
    input  logic [WVAL_W-1:0]                      wt_rdata,
    output mac_ctl_t                               mac_ctl,
    output logic signed [MUL_A_W-1:0]              mac_a,
    output logic signed [MUL_B_W-1:0]              mac_b,
    input  logic signed [PROD_W-1:0]               mac_acc,
    input  logic                                   out_busy,
    output logic                                   res_push,
    output logic signed [SAMPLE_BITS-1:0]          res_value,
    output logic                                   res_last,
    output logic                                   busy
);

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH;
    localparam int PTR_W     = $clog2(WIN_DEPTH);
    localparam int K_W       = PTR_W;
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int RNG_W     = $clog2(MAX_HALF_WIDTH + 1);
    localparam int HOLD_W    = PROD_W - MUL_B_W;
    localparam int NCH       = HOLD_W / CHUNK_W;
    localparam int CH_W      = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int R_W       = PROD_W - FRAC_BITS;

    localparam logic signed [PROD_W-1:0] RND_ADD = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [R_W-1:0]    SAT_MAX =
        R_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [R_W-1:0]    SAT_MIN = ~SAT_MAX;

    seq_state_t          state_reg, state_next;
    logic [RNG_W-1:0]    d_reg, d_next;
    logic [RNG_W-1:0]    range_reg, range_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic                main_reg, main_next;
    logic                end_reg, end_next;
    logic [K_W-1:0]      k_reg, k_next;
    logic [PTR_W-1:0]    addr_reg, addr_next;
    logic [1:0]          wait_reg, wait_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic [HOLD_W-1:0]   hold_reg, hold_next;
    logic                tap_v_reg;
    logic                tap_ok_reg;
    logic                tap_first_reg;

    logic                kend_hit;
    logic                tap_ok;
    logic [K_W:0]        dist_w;
    logic [PTR_W-1:0]    addr_dec;
    logic [PTR_W-1:0]    head_inc;
    logic                start_main;
    logic [RNG_W-1:0]    start_flush_d;
    logic                more_out;
    logic [CHUNK_W-1:0]  chunk;
    logic signed [PROD_W-1:0] rnd_sum;
    logic signed [R_W-1:0]    round_r;

    // Tap bookkeeping
    assign kend_hit = ((K_W+1)'(k_reg) ==
                       (K_W+1)'(d_reg) + (K_W+1)'(range_reg) - (K_W+1)'(1));
    assign tap_ok   = (CNT_W'(k_reg) <= n_reg);

    always_comb
    begin
        if ((K_W+1)'(k_reg) <= (K_W+1)'(d_reg))
        begin
            dist_w = (K_W+1)'(d_reg) - (K_W+1)'(k_reg);
        end
        else
        begin
            dist_w = (K_W+1)'(k_reg) - (K_W+1)'(d_reg);
        end
    end

    assign addr_dec = (addr_reg == '0) ? PTR_W'(WIN_DEPTH - 1) : addr_reg - PTR_W'(1);
    assign head_inc = (head == PTR_W'(WIN_DEPTH - 1)) ? '0 : head + PTR_W'(1);

    // Decide which outputs a new sample releases
    assign start_main = (32'(start_n) >= 32'(start_range));

    always_comb
    begin
        if (32'(start_n) < 32'(start_range) - 32'd1)
        begin
            start_flush_d = RNG_W'(start_n);
        end
        else
        begin
            start_flush_d = start_range - RNG_W'(1);
        end
    end

    assign more_out = (main_reg && end_reg) || (!main_reg && (d_reg != '0));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (start_main || start_end))
                begin
                    state_next = ST_TAP;
                end
            end
            ST_TAP:
            begin
                if (kend_hit)
                begin
                    state_next = ST_TAP_WAIT;
                end
            end
            ST_TAP_WAIT:
            begin
                if (wait_reg == '0)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                if (ch_reg == '0)
                begin
                    state_next = ST_SCALE_WAIT;
                end
            end
            ST_SCALE_WAIT:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!out_busy)
                begin
                    state_next = more_out ? ST_TAP : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        d_next     = d_reg;
        range_next = range_reg;
        n_next     = n_reg;
        main_next  = main_reg;
        end_next   = end_reg;
        k_next     = k_reg;
        addr_next  = addr_reg;
        wait_next  = wait_reg;
        ch_next    = ch_reg;
        hold_next  = hold_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    range_next = start_range;
                    n_next     = start_n;
                    end_next   = start_end;
                    main_next  = start_main;
                    d_next     = start_main ? start_range : start_flush_d;
                    k_next     = '0;
                    addr_next  = head_inc;
                end
            end
            ST_TAP:
            begin
                k_next    = k_reg + K_W'(1);
                addr_next = addr_dec;
                wait_next = TAP_DRAIN;
            end
            ST_TAP_WAIT:
            begin
                wait_next = wait_reg - 2'd1;
                if (wait_reg == '0)
                begin
                    hold_next = mac_acc[HOLD_W-1:0];
                    ch_next   = CH_W'(NCH - 1);
                end
            end
            ST_SCALE:
            begin
                hold_next = hold_reg << CHUNK_W;
                ch_next   = ch_reg - CH_W'(1);
            end
            ST_ROUND:
            begin
                if (!out_busy)
                begin
                    k_next    = '0;
                    addr_next = head;
                    main_next = 1'b0;
                    if (main_reg)
                    begin
                        d_next = range_reg - RNG_W'(1);
                    end
                    else
                    begin
                        d_next = d_reg - RNG_W'(1);
                    end
                end
            end
            default:
            begin
                d_next = d_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tap_v_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_v_reg <= (state_reg == ST_TAP);
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg         <= d_next;
        range_reg     <= range_next;
        n_reg         <= n_next;
        main_reg      <= main_next;
        end_reg       <= end_next;
        k_reg         <= k_next;
        addr_reg      <= addr_next;
        wait_reg      <= wait_next;
        ch_reg        <= ch_next;
        hold_reg      <= hold_next;
        tap_ok_reg    <= tap_ok;
        tap_first_reg <= (k_reg == '0);
    end

    // Round half up and saturate
    assign rnd_sum = mac_acc + RND_ADD;
    assign round_r = rnd_sum[PROD_W-1:FRAC_BITS];
    assign chunk   = hold_reg[HOLD_W-1 -: CHUNK_W];

    // Outputs: memory addresses, shared unit operands, result hand-off
    always_comb
    begin
        win_raddr = addr_reg;
        wt_raddr  = RNG_W'(dist_w);
        busy      = (state_reg != ST_IDLE);
        res_push  = (state_reg == ST_ROUND) && !out_busy;
        res_last  = !main_reg && (d_reg == '0);

        if (round_r > SAT_MAX)
        begin
            res_value = SAMPLE_BITS'(SAT_MAX);
        end
        else if (round_r < SAT_MIN)
        begin
            res_value = SAMPLE_BITS'(SAT_MIN);
        end
        else
        begin
            res_value = SAMPLE_BITS'(round_r);
        end

        if (state_reg == ST_SCALE)
        begin
            mac_ctl.en = 1'b1;
            mac_b      = MUL_B_W'(scale);
            if (ch_reg == CH_W'(NCH - 1))
            begin
                mac_ctl.op = MAC_LOAD;
                mac_a      = MUL_A_W'($signed(chunk));
            end
            else
            begin
                mac_ctl.op = MAC_SHADD;
                mac_a      = MUL_A_W'(chunk);
            end
        end
        else
        begin
            mac_ctl.en = tap_v_reg;
            mac_ctl.op = tap_first_reg ? MAC_LOAD : MAC_ADD;
            mac_a      = tap_ok_reg ? MUL_A_W'(win_rdata) : '0;
            mac_b      = MUL_B_W'(wt_rdata);
        end
    end

endmodule

/* src/gaussian_broadening_fir_core.sv */
// ----------------------------------------------------------------------------
// gaussian_broadening_fir_core: truncated Gaussian smoothing FIR over blocks
// Load requests fill the kernel weight table; sample requests enter the
// window and release zero or more broadened output samples.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): req_type selects a weight load or a
//   sample. A load produces nothing. A sample is accepted only while the
//   block is idle; in_stall stays high until every output that sample
//   releases has been computed and handed to the output register.
//   Each output walks (d + range) taps through the shared multiply-
//   accumulate unit, where d is its distance from the newest sample (up to
//   range) and range is the effective half width, then drains, scales in
//   chunks (NCH = 3 chunks at default sizes) and rounds.
//   Output channel (out_valid / out_stall): one output register. While the
//   receiver stalls, a computed result waits in the sequencer and the
//   input stays stalled. The next sample can be accepted while the last
//   result still sits in the output register.
//   Reset clears the registers to their defaults, empties the block and the
//   output register. The weight table holds no defined values until loaded.
//   Configuration writes are taken at any cycle; write them while idle.
// ----------------------------------------------------------------------------
module gaussian_broadening_fir_core
    import gbf_pkg::*;
#(
    parameter int MAX_HALF_WIDTH = 32,
    parameter int SAMPLE_BITS    = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [WIDX_W-1:0]             weight_index,
    input  logic [WVAL_W-1:0]             weight_value,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          block_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] smoothed,
    output logic                          last_out
);

    localparam int WIN_DEPTH = 2 * MAX_HALF_WIDTH;
    localparam int PTR_W     = $clog2(WIN_DEPTH);
    localparam int CNT_W     = $clog2(WIN_DEPTH + 1);
    localparam int RNG_W     = $clog2(MAX_HALF_WIDTH + 1);
    localparam int ACC_W     = SAMPLE_BITS + WVAL_W + $clog2(WIN_DEPTH);
    localparam int NCH       = (ACC_W + CHUNK_W - 1) / CHUNK_W;
    localparam int MUL_A_W   = (SAMPLE_BITS > CHUNK_W + 1) ? SAMPLE_BITS : CHUNK_W + 1;
    localparam int MUL_B_W   = SCALE_W + 1;
    localparam int PROD_W    = NCH * CHUNK_W + MUL_B_W;

    logic [HW_W-1:0]               half_width_reg;
    logic [SCALE_W-1:0]            output_scale_reg;
    logic [THR_W-1:0]              skip_threshold_reg;
    logic [CNT_W-1:0]              samples_seen_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] smoothed_reg;
    logic                          last_out_reg;

    logic                          in_accept;
    logic                          sample_accept;
    logic                          wt_we;
    logic [SAMPLE_BITS-1:0]        sample_mag;
    logic signed [SAMPLE_BITS-1:0] sample_kept;
    logic [RNG_W-1:0]              range_eff;
    logic                          seq_busy;
    logic                          out_busy;
    logic [PTR_W-1:0]              head;
    logic [PTR_W-1:0]              win_raddr;
    logic [RNG_W-1:0]              wt_raddr;
    logic signed [SAMPLE_BITS-1:0] win_rdata;
    logic [WVAL_W-1:0]             wt_rdata;
    mac_ctl_t                      mac_ctl;
    logic signed [MUL_A_W-1:0]     mac_a;
    logic signed [MUL_B_W-1:0]     mac_b;
    logic signed [PROD_W-1:0]      mac_acc;
    logic                          res_push;
    logic signed [SAMPLE_BITS-1:0] res_value;
    logic                          res_last;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg     <= HALF_WIDTH_RST;
            output_scale_reg   <= OUTPUT_SCALE_RST;
            skip_threshold_reg <= SKIP_THRESH_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_WIDTH:     half_width_reg     <= cfg_data[HW_W-1:0];
                REG_OUTPUT_SCALE:   output_scale_reg   <= cfg_data[SCALE_W-1:0];
                REG_SKIP_THRESHOLD: skip_threshold_reg <= cfg_data[THR_W-1:0];
                default:            half_width_reg     <= half_width_reg;
            endcase
        end
    end

    // Clamp the half width to the supported reach
    always_comb
    begin
        if (half_width_reg == '0)
        begin
            range_eff = RNG_W'(1);
        end
        else if (32'(half_width_reg) > 32'(MAX_HALF_WIDTH))
        begin
            range_eff = RNG_W'(MAX_HALF_WIDTH);
        end
        else
        begin
            range_eff = RNG_W'(half_width_reg);
        end
    end

    // Request decode
    assign in_stall      = seq_busy;
    assign in_accept     = in_valid && !in_stall;
    assign sample_accept = in_accept && (req_type == REQ_SAMPLE);
    assign wt_we         = in_accept && (req_type == REQ_LOAD) &&
                           (32'(weight_index) <= 32'(MAX_HALF_WIDTH));

    // Zero samples whose magnitude is below the threshold
    assign sample_mag  = sample[SAMPLE_BITS-1] ? (~sample + SAMPLE_BITS'(1)) : sample;
    assign sample_kept = (32'(sample_mag) < 32'(skip_threshold_reg)) ? '0 : sample;

    // Count samples of the current block, saturating at the window depth; a block-end sample clears it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samples_seen_reg <= '0;
        end
        else if (sample_accept)
        begin
            if (block_end)
            begin
                samples_seen_reg <= '0;
            end
            else if (samples_seen_reg < CNT_W'(WIN_DEPTH))
            begin
                samples_seen_reg <= samples_seen_reg + CNT_W'(1);
            end
        end
    end

    gbf_store #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .wt_we     (wt_we),
        .wt_waddr  (RNG_W'(weight_index)),
        .wt_wdata  (weight_value),
        .win_we    (sample_accept),
        .win_wdata (sample_kept),
        .win_raddr (win_raddr),
        .wt_raddr  (wt_raddr),
        .win_rdata (win_rdata),
        .wt_rdata  (wt_rdata),
        .head      (head)
    );

    gbf_mac #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W),
        .P_W (PROD_W)
    ) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (mac_acc)
    );

    gbf_seq #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .MUL_A_W        (MUL_A_W),
        .MUL_B_W        (MUL_B_W),
        .PROD_W         (PROD_W)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (sample_accept),
        .start_range (range_eff),
        .start_n     (samples_seen_reg),
        .start_end   (block_end),
        .scale       (output_scale_reg),
        .head        (head),
        .win_raddr   (win_raddr),
        .wt_raddr    (wt_raddr),
        .win_rdata   (win_rdata),
        .wt_rdata    (wt_rdata),
        .mac_ctl     (mac_ctl),
        .mac_a       (mac_a),
        .mac_b       (mac_b),
        .mac_acc     (mac_acc),
        .out_busy    (out_busy),
        .res_push    (res_push),
        .res_value   (res_value),
        .res_last    (res_last),
        .busy        (seq_busy)
    );

    // Output register: load a result, release it when the receiver takes it
    assign out_busy = out_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            smoothed_reg <= res_value;
            last_out_reg <= res_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign smoothed  = smoothed_reg;
    assign last_out  = last_out_reg;

`ifndef SYNTHESIS
    // A new result never lands on a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !(out_valid_reg && out_stall))
        else $error("result pushed into a held output register");

    // A weight load starts no output work
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == REQ_LOAD)) |=> !seq_busy)
        else $error("weight load started the sequencer");

    // The block sample count saturates at the window depth
    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        samples_seen_reg <= CNT_W'(WIN_DEPTH))
        else $error("sample count beyond window depth");
`endif

endmodule
